>>> rtl/core/smie_pkg.sv
package smie_pkg;

    localparam int DATA_W          = 32;
    localparam int NAME_W          = 31;
    localparam int CFG_W           = 6;
    localparam int STACK_DEPTH_DEF = 32;
    localparam int DIV_STEPS       = 32;
    localparam logic [CFG_W-1:0] LIMIT_RESET = 6'd32;

    typedef enum logic [3:0] {
        ACT_RETURN = 4'd0,
        ACT_PUSH   = 4'd1,
        ACT_ZERO   = 4'd2,
        ACT_ONE    = 4'd3,
        ACT_NOT    = 4'd4,
        ACT_EQ     = 4'd5,
        ACT_DUP    = 4'd6,
        ACT_POP    = 4'd7,
        ACT_ADD    = 4'd8,
        ACT_MUL    = 4'd9,
        ACT_DIV    = 4'd10,
        ACT_STORE  = 4'd11,
        ACT_JUMP   = 4'd12,
        ACT_BRF    = 4'd13,
        ACT_NOP    = 4'd14,
        ACT_UNSUP  = 4'd15
    } action_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2,
        ERR_UNSUP     = 2'd3
    } err_t;

    typedef struct packed {
        action_t                   action;
        logic signed [DATA_W-1:0]  param;
    } in_item_t;

    typedef struct packed {
        logic                      store_valid;
        logic [NAME_W-1:0]         store_name;
        logic signed [DATA_W-1:0]  store_value;
        logic                      branch_taken;
        logic signed [DATA_W-1:0]  branch_offset;
        logic                      halted;
        err_t                      error_code;
    } out_item_t;

endpackage

>>> rtl/core/stack_machine_init_evaluator_core.sv
// A request's result is registered from the execute state; a divide of two nonzero
// operands first passes a check in the execute state, then runs 32 restoring steps of
// the divider before its result is registered. A new request is taken only when the
// sequencer is idle, and a result that finds the output register full waits in a side
// register, holding the sequencer until it drains.
// Reset (aresetn, synchronous, active low): empty stack, not halted, limit 32, not ready.
module stack_machine_init_evaluator_core
    import smie_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int CW  = ((SPW > CFG_W) ? SPW : CFG_W) + 1;
    localparam int DCW = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_OUT
    } state_t;

    state_t              state_reg;
    in_item_t            item_reg;
    logic [SPW-1:0]      sp_reg;
    logic                done_reg;
    logic [CFG_W-1:0]    limit_reg;
    logic                m_valid_reg;
    out_item_t           m_data_reg;
    out_item_t           pend_reg;

    logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0]   rd_a_reg;
    logic [DATA_W-1:0]   rd_b_reg;

    logic [DATA_W-1:0]   div_rem_reg;
    logic [DATA_W-1:0]   div_quo_reg;
    logic [DATA_W-1:0]   div_den_reg;
    logic                div_neg_reg;
    logic [DCW-1:0]      div_cnt_reg;

    // Decode and check signals
    logic [1:0]          pops;
    logic [1:0]          pushes;
    logic                under;
    logic                over;
    logic                legal;
    logic [DATA_W-1:0]   r_exec;
    out_item_t           res_exec;
    logic [CW-1:0]       sp_ext;
    logic [CW-1:0]       lim_ext;
    logic [SPW-1:0]      sp_next;
    logic [SPW-1:0]      wr_ptr;
    logic [SPW-1:0]      rd_ptr_a;
    logic [SPW-1:0]      rd_ptr_b;
    logic                div_start;
    logic                div_last;
    logic                commit_en;
    logic                slot_free;

    // Divider step signals
    logic [DATA_W:0]     div_shift;
    logic [DATA_W:0]     div_diff;
    logic [DATA_W-1:0]   div_quo_next;
    logic [DATA_W-1:0]   div_result;
    logic                a_neg;
    logic                b_neg;
    logic [DATA_W-1:0]   a_mag;
    logic [DATA_W-1:0]   b_mag;

    logic                mem_we;
    logic [DATA_W-1:0]   mem_wdata;

    assign s_ready   = aresetn && (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign slot_free = !m_valid_reg || m_ready;

    assign rd_ptr_b = sp_reg - SPW'(1);
    assign rd_ptr_a = sp_reg - SPW'(2);

    // Effective limit: smaller of the register and the stack depth
    assign sp_ext  = CW'(sp_reg);
    assign lim_ext = (CW'(limit_reg) < CW'(STACK_DEPTH)) ? CW'(limit_reg)
                                                         : CW'(STACK_DEPTH);

    // Decode the stack effect of the held request
    always_comb begin
        pops   = 2'd0;
        pushes = 2'd0;
        unique case (item_reg.action)
            ACT_PUSH, ACT_ZERO, ACT_ONE:         pushes = 2'd1;
            ACT_NOT:                             begin pops = 2'd1; pushes = 2'd1; end
            ACT_EQ, ACT_ADD, ACT_MUL, ACT_DIV:   begin pops = 2'd2; pushes = 2'd1; end
            ACT_DUP:                             begin pops = 2'd1; pushes = 2'd2; end
            ACT_POP, ACT_STORE, ACT_BRF:         pops = 2'd1;
            ACT_RETURN, ACT_JUMP, ACT_NOP, ACT_UNSUP: ;
            default: ;
        endcase
    end

    assign under   = sp_ext < CW'(pops);
    assign over    = (sp_ext - CW'(pops) + CW'(pushes)) > lim_ext;
    assign sp_next = sp_reg - SPW'(pops) + SPW'(pushes);
    assign wr_ptr  = (item_reg.action == ACT_DUP) ? sp_reg : sp_reg - SPW'(pops);

    // Shared ALU: one operation per request
    always_comb begin
        unique case (item_reg.action)
            ACT_PUSH: r_exec = item_reg.param;
            ACT_ONE:  r_exec = DATA_W'(1);
            ACT_NOT:  r_exec = DATA_W'(rd_b_reg == '0);
            ACT_EQ:   r_exec = DATA_W'(rd_a_reg == rd_b_reg);
            ACT_DUP:  r_exec = rd_b_reg;
            ACT_ADD:  r_exec = rd_a_reg + rd_b_reg;
            ACT_MUL:  r_exec = rd_a_reg * rd_b_reg;
            default:  r_exec = '0;
        endcase
    end

    // Build the result fields; order decides
    always_comb begin
        res_exec = '0;
        legal    = 1'b0;
        priority if (done_reg) begin
            res_exec.halted = 1'b1;
        end else if (item_reg.action == ACT_RETURN) begin
            res_exec.halted = 1'b1;
        end else if (item_reg.action == ACT_JUMP) begin
            res_exec.branch_taken  = 1'b1;
            res_exec.branch_offset = item_reg.param;
        end else if (item_reg.action == ACT_NOP) begin
            res_exec = '0;
        end else if (item_reg.action == ACT_UNSUP) begin
            res_exec.error_code = ERR_UNSUP;
        end else if (under) begin
            res_exec.error_code = ERR_UNDERFLOW;
        end else if (over) begin
            res_exec.error_code = ERR_OVERFLOW;
        end else begin
            legal = 1'b1;
            if (item_reg.action == ACT_STORE) begin
                res_exec.store_valid = 1'b1;
                res_exec.store_name  = item_reg.param[NAME_W-1:0];
                res_exec.store_value = rd_b_reg;
            end
            if (item_reg.action == ACT_BRF && rd_b_reg == '0) begin
                res_exec.branch_taken  = 1'b1;
                res_exec.branch_offset = item_reg.param;
            end
        end
    end

    // Divider operands as sign and magnitude
    assign a_neg = rd_a_reg[DATA_W-1];
    assign b_neg = rd_b_reg[DATA_W-1];
    assign a_mag = a_neg ? (DATA_W'(0) - rd_a_reg) : rd_a_reg;
    assign b_mag = b_neg ? (DATA_W'(0) - rd_b_reg) : rd_b_reg;

    assign div_start = (state_reg == S_EXEC) && legal && (item_reg.action == ACT_DIV)
                       && (rd_a_reg != '0) && (rd_b_reg != '0);

    // One restoring step per cycle
    assign div_shift    = {div_rem_reg, div_quo_reg[DATA_W-1]};
    assign div_diff     = div_shift - {1'b0, div_den_reg};
    assign div_quo_next = {div_quo_reg[DATA_W-2:0], ~div_diff[DATA_W]};
    assign div_result   = div_neg_reg ? (DATA_W'(0) - div_quo_next) : div_quo_next;
    assign div_last     = (state_reg == S_DIV) && (div_cnt_reg == DCW'(DIV_STEPS - 1));

    assign commit_en = ((state_reg == S_EXEC) && !div_start) || div_last;
    assign mem_we    = commit_en && legal && (pushes != 2'd0);
    assign mem_wdata = (state_reg == S_DIV) ? div_result : r_exec;

    // Sequencer, stack pointer, configuration and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sp_reg      <= '0;
            done_reg    <= 1'b0;
            limit_reg   <= LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (commit_en && legal) begin
                sp_reg <= sp_next;
            end
            if (commit_en && !done_reg && item_reg.action == ACT_RETURN) begin
                done_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        item_reg  <= s_data;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (div_start) begin
                        div_rem_reg <= '0;
                        div_quo_reg <= a_mag;
                        div_den_reg <= b_mag;
                        div_neg_reg <= a_neg ^ b_neg;
                        div_cnt_reg <= '0;
                        state_reg   <= S_DIV;
                    end else if (slot_free) begin
                        m_data_reg  <= res_exec;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end else begin
                        pend_reg  <= res_exec;
                        state_reg <= S_OUT;
                    end
                end
                S_DIV: begin
                    div_rem_reg <= div_diff[DATA_W] ? div_shift[DATA_W-1:0]
                                                    : div_diff[DATA_W-1:0];
                    div_quo_reg <= div_quo_next;
                    div_cnt_reg <= div_cnt_reg + DCW'(1);
                    if (div_last) begin
                        if (slot_free) begin
                            m_data_reg  <= res_exec;
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_IDLE;
                        end else begin
                            pend_reg  <= res_exec;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (slot_free) begin
                        m_data_reg  <= pend_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Stack memory: operand read on acceptance, one write on commit
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[wr_ptr[AW-1:0]] <= mem_wdata;
        end
        if (state_reg == S_IDLE && s_valid) begin
            rd_b_reg <= stack_mem[rd_ptr_b[AW-1:0]];
            rd_a_reg <= stack_mem[rd_ptr_a[AW-1:0]];
        end
    end

    // Checks
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> done_reg)
        else $error("halt flag cleared while running");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (div_den_reg != '0))
        else $error("divider running with zero divisor");

    a_sp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_OUT) |=> $stable(sp_reg))
        else $error("stack pointer moved outside execution");

    a_halt_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.halted) |->
            (m_data_reg.error_code == ERR_NONE && !m_data_reg.store_valid
             && !m_data_reg.branch_taken))
        else $error("halted result carries other fields");

endmodule
